/* sv/hdkd_pkg.sv */
`timescale 1ns / 1ps
// package: sizes, hash constants, controller states and command/status types
package hdkd_pkg;

    localparam int CAPACITY   = 256;
    localparam int KEY_BITS   = 32;
    localparam int SLOT_COUNT = 2 * CAPACITY;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int ORD_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int TAG_W      = CNT_W;
    localparam int FIELD_W    = 32;
    localparam int ORD_OUT_W  = 8;
    localparam int HASH_SHIFT = 16;

    localparam logic [FIELD_W-1:0] HASH_MUL = 32'd2654435769;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_ENT,
        ST_CHECK
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic rd_home;
        logic rd_ent;
        logic rd_next;
        logic res_dup;
        logic res_empty;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic hit;
        logic empty;
        logic out_free;
    } t_dp_sts;

endpackage

/* sv/hdkd_if.sv */
`timescale 1ns / 1ps
// interfaces: request and result channels
interface hdkd_req_if;
    logic                         valid;
    logic                         ready;
    logic                         new_dict;
    logic [hdkd_pkg::FIELD_W-1:0] key;
    logic [hdkd_pkg::FIELD_W-1:0] payload;

    modport source(output valid, new_dict, key, payload, input ready);
    modport sink(input valid, new_dict, key, payload, output ready);
endinterface

interface hdkd_res_if;
    logic                           valid;
    logic                           ready;
    logic                           duplicate;
    logic                           full_res;
    logic [hdkd_pkg::ORD_OUT_W-1:0] ordinal;
    logic [hdkd_pkg::FIELD_W-1:0]   prior_payload;

    modport source(output valid, duplicate, full_res, ordinal, prior_payload, input ready);
    modport sink(input valid, duplicate, full_res, ordinal, prior_payload, output ready);
endinterface

/* sv/hdkd_ctrl.sv */
`timescale 1ns / 1ps
// controller: sequences hashing, slot probing and result commit
module hdkd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  hdkd_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output hdkd_pkg::t_dp_cmd o_cmd
);

    hdkd_pkg::t_state r_state;
    hdkd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hdkd_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            hdkd_pkg::ST_CLEAR: begin
                if (i_sts.clr_done) n_state = hdkd_pkg::ST_IDLE;
            end
            hdkd_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = hdkd_pkg::ST_HASH;
            end
            hdkd_pkg::ST_HASH: begin
                n_state = hdkd_pkg::ST_ENT;
            end
            hdkd_pkg::ST_ENT: begin
                n_state = hdkd_pkg::ST_CHECK;
            end
            hdkd_pkg::ST_CHECK: begin
                if (!i_sts.hit && !i_sts.empty) begin
                    n_state = hdkd_pkg::ST_ENT;
                end else if (i_sts.out_free) begin
                    n_state = hdkd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hdkd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            hdkd_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            hdkd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            hdkd_pkg::ST_HASH: begin
                o_cmd.rd_home = 1'b1;
            end
            hdkd_pkg::ST_ENT: begin
                o_cmd.rd_ent = 1'b1;
            end
            hdkd_pkg::ST_CHECK: begin
                if (!i_sts.hit && !i_sts.empty) begin
                    o_cmd.rd_next = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.res_dup   = i_sts.hit;
                    o_cmd.res_empty = i_sts.empty;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* sv/hdkd_dpath.sv */
`timescale 1ns / 1ps
// datapath: hash, slot table, entry store, entry count and result register
module hdkd_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_new_dict,
    input  logic [hdkd_pkg::FIELD_W-1:0] i_key,
    input  logic [hdkd_pkg::FIELD_W-1:0] i_payload,
    input  hdkd_pkg::t_dp_cmd            i_cmd,
    output hdkd_pkg::t_dp_sts            o_sts,
    hdkd_res_if.source                   o_res
);

    logic [hdkd_pkg::TAG_W-1:0]    slot_mem [hdkd_pkg::SLOT_COUNT];
    logic [hdkd_pkg::KEY_BITS-1:0] key_mem  [hdkd_pkg::CAPACITY];
    logic [hdkd_pkg::FIELD_W-1:0]  pay_mem  [hdkd_pkg::CAPACITY];
    logic [hdkd_pkg::SLOT_W-1:0]   home_mem [hdkd_pkg::CAPACITY];

    logic [hdkd_pkg::KEY_BITS-1:0] r_key;
    logic [hdkd_pkg::FIELD_W-1:0]  r_pay;
    logic [hdkd_pkg::FIELD_W-1:0]  r_prod;
    logic [hdkd_pkg::SLOT_W-1:0]   r_slot;
    logic [hdkd_pkg::TAG_W-1:0]    r_tag;
    logic [hdkd_pkg::KEY_BITS-1:0] r_ent_key;
    logic [hdkd_pkg::FIELD_W-1:0]  r_ent_pay;
    logic [hdkd_pkg::SLOT_W-1:0]   r_ent_slot;
    logic [hdkd_pkg::CNT_W-1:0]    r_count;
    logic [hdkd_pkg::SLOT_W-1:0]   r_clr_addr;

    logic                           r_out_valid;
    logic                           r_out_dup;
    logic                           r_out_full;
    logic [hdkd_pkg::ORD_OUT_W-1:0] r_out_ord;
    logic [hdkd_pkg::FIELD_W-1:0]   r_out_pay;

    logic [hdkd_pkg::KEY_BITS-1:0] w_key_m;
    logic [hdkd_pkg::FIELD_W-1:0]  w_prod;
    logic [hdkd_pkg::FIELD_W-1:0]  w_hash;
    logic [hdkd_pkg::SLOT_W-1:0]   w_home;
    logic [hdkd_pkg::SLOT_W-1:0]   w_next;
    logic [hdkd_pkg::SLOT_W-1:0]   w_slot_addr;
    logic [hdkd_pkg::TAG_W-1:0]    w_tag_m1;
    logic [hdkd_pkg::ORD_W-1:0]    w_ent_idx;
    logic [hdkd_pkg::ORD_W-1:0]    w_cnt_idx;
    logic [hdkd_pkg::TAG_W-1:0]    w_new_tag;
    logic                          w_live;
    logic                          w_hit;
    logic                          w_room;
    logic                          w_ins;
    logic                          w_out_free;

    // key truncated to the compared width, then fibonacci multiply
    assign w_key_m = i_key[hdkd_pkg::KEY_BITS-1:0];
    assign w_prod  = hdkd_pkg::FIELD_W'(w_key_m) * hdkd_pkg::HASH_MUL;

    assign w_hash      = r_prod ^ (r_prod >> hdkd_pkg::HASH_SHIFT);
    assign w_home      = w_hash[hdkd_pkg::SLOT_W-1:0];
    assign w_next      = r_slot + hdkd_pkg::SLOT_W'(1);
    assign w_slot_addr = i_cmd.rd_home ? w_home : w_next;

    assign w_tag_m1  = r_tag - hdkd_pkg::TAG_W'(1);
    assign w_ent_idx = w_tag_m1[hdkd_pkg::ORD_W-1:0];
    assign w_cnt_idx = r_count[hdkd_pkg::ORD_W-1:0];
    assign w_new_tag = r_count + hdkd_pkg::CNT_W'(1);

    // a slot is live only if its entry belongs to this dictionary and points back here
    assign w_live = (r_tag != '0) && (r_tag <= r_count) && (r_ent_slot == r_slot);
    assign w_hit  = w_live && (r_ent_key == r_key);
    assign w_room = r_count < hdkd_pkg::CNT_W'(hdkd_pkg::CAPACITY);
    assign w_ins  = i_cmd.res_empty && w_room;

    assign w_out_free = !r_out_valid || o_res.ready;

    assign o_sts.clr_done = (r_clr_addr == hdkd_pkg::SLOT_W'(hdkd_pkg::SLOT_COUNT - 1));
    assign o_sts.hit      = w_hit;
    assign o_sts.empty    = !w_live;
    assign o_sts.out_free = w_out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= w_key_m;
            r_pay  <= i_payload;
            r_prod <= w_prod;
        end
    end

    // slot table
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_home || i_cmd.rd_next) begin
            r_tag  <= slot_mem[w_slot_addr];
            r_slot <= w_slot_addr;
        end
        if (i_cmd.clear) begin
            slot_mem[r_clr_addr] <= '0;
        end else if (w_ins) begin
            slot_mem[r_slot] <= w_new_tag;
        end
    end

    // clearing pass after reset, one slot a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + hdkd_pkg::SLOT_W'(1);
        end
    end

    // entry store
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_ent) begin
            r_ent_key  <= key_mem[w_ent_idx];
            r_ent_pay  <= pay_mem[w_ent_idx];
            r_ent_slot <= home_mem[w_ent_idx];
        end
        if (w_ins) begin
            key_mem[w_cnt_idx]  <= r_key;
            pay_mem[w_cnt_idx]  <= r_pay;
            home_mem[w_cnt_idx] <= r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load && i_new_dict) begin
            r_count <= '0;
        end else if (w_ins) begin
            r_count <= w_new_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_dup || i_cmd.res_empty) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_dup) begin
            r_out_dup  <= 1'b1;
            r_out_full <= 1'b0;
            r_out_ord  <= hdkd_pkg::ORD_OUT_W'(w_ent_idx);
            r_out_pay  <= r_ent_pay;
        end else if (i_cmd.res_empty) begin
            r_out_dup  <= 1'b0;
            r_out_full <= !w_room;
            r_out_ord  <= w_room ? hdkd_pkg::ORD_OUT_W'(r_count) : '0;
            r_out_pay  <= '0;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.duplicate     = r_out_dup;
    assign o_res.full_res      = r_out_full;
    assign o_res.ordinal       = r_out_ord;
    assign o_res.prior_payload = r_out_pay;

endmodule

/* sv/hashed_duplicate_key_detector_core.sv */
`timescale 1ns / 1ps
// top level: duplicate key detector built on a linear probing hash set
//
// i_req carries one request: new_dict, key and payload. o_res returns one
// result per request: duplicate, full_res, ordinal and prior_payload.
// A request with new_dict set empties the dictionary before its key is used.
// Keys are hashed by a fibonacci multiply, xor-folded and masked to a slot
// table of twice the capacity, then probed one slot at a time.
// After a request is accepted the home slot is read, then its entry, then the
// check decides; each further slot probed repeats the slot and entry reads.
// The serial slot-then-entry memory read per probe means a new request is
// taken only once the last lookup ends. i_req.ready is high only while idle.
// After reset a clearing pass empties the slot table one slot a cycle, and
// i_req.ready stays low until it ends. Later a slot counts only when its
// ordinal is below the entry count and that entry points back to the slot,
// so new_dict needs no clearing pass.
// The result sits in an output register; the next request is accepted while it
// waits. If o_res is stalled, a finished lookup holds until the register frees.
module hashed_duplicate_key_detector_core (
    input  logic     i_clk,
    input  logic     i_rst_n,
    hdkd_req_if.sink i_req,
    hdkd_res_if.source o_res
);

    hdkd_pkg::t_dp_cmd w_cmd;
    hdkd_pkg::t_dp_sts w_sts;
    logic              w_in_ready;

    assign i_req.ready = w_in_ready;

    hdkd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    hdkd_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_new_dict (i_req.new_dict),
        .i_key      (i_req.key),
        .i_payload  (i_req.payload),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_res      (o_res)
    );

endmodule

/* sv/hdkd_checker.sv */
`timescale 1ns / 1ps
// checker: port-level properties of the detector, bound to the top level
module hdkd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_dup,
    input logic                           i_full,
    input logic [hdkd_pkg::ORD_OUT_W-1:0] i_ord,
    input logic [hdkd_pkg::FIELD_W-1:0]   i_prior
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while previous lookup in flight");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_dup && i_full))
        else $error("duplicate and full together");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_full |-> (i_ord == '0) && (i_prior == '0))
        else $error("full result carries data");

    a_prior_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_dup |-> i_prior == '0)
        else $error("prior payload without duplicate");

endmodule

bind hashed_duplicate_key_detector_core hdkd_checker u_hdkd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_dup       (o_res.duplicate),
    .i_full      (o_res.full_res),
    .i_ord       (o_res.ordinal),
    .i_prior     (o_res.prior_payload)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// testbench: duplicate key detector checked against a hash set predictor, random handshakes
module tb_top;
    import hdkd_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RST_CYCLES  = 7;
    localparam int TOTAL_REQS  = 1950;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int TAIL_CYCLES = 24;
    localparam int LONG_HOLD   = 400;
    localparam int MAX_REPORTS = 40;
    localparam int OLD_KEEP    = 64;

    typedef struct packed {
        logic                 duplicate;
        logic                 full_res;
        logic [ORD_OUT_W-1:0] ordinal;
        logic [FIELD_W-1:0]   prior_payload;
    } t_lookup_res;

    class t_dict_scoreboard;
        logic [TAG_W-1:0]   slot_tags [SLOT_COUNT];
        logic [FIELD_W-1:0] entry_keys [CAPACITY];
        logic [FIELD_W-1:0] entry_pays [CAPACITY];
        int unsigned        n_entries;
        t_lookup_res        awaited_results [$];
        int unsigned        n_checked, n_dup, n_full, n_insert, n_clear;
        int unsigned        n_errors, longest_probe;

        function new();
            foreach (entry_keys[i]) begin
                entry_keys[i] = '0;
                entry_pays[i] = '0;
            end
            clear_dict();
            n_checked     = 0;
            n_dup         = 0;
            n_full        = 0;
            n_insert      = 0;
            n_clear       = 0;
            n_errors      = 0;
            longest_probe = 0;
        endfunction

        function void clear_dict();
            foreach (slot_tags[i]) slot_tags[i] = '0;
            n_entries = 0;
        endfunction

        function logic [FIELD_W-1:0] key_mask();
            return (KEY_BITS >= FIELD_W) ? {FIELD_W{1'b1}}
                                         : ((FIELD_W'(1) << KEY_BITS) - FIELD_W'(1));
        endfunction

        function int unsigned slot_of(logic [FIELD_W-1:0] key);
            logic [FIELD_W-1:0] h;
            h = (key & key_mask()) * HASH_MUL;
            h = h ^ (h >> HASH_SHIFT);
            return int'(h & FIELD_W'(SLOT_COUNT - 1));
        endfunction

        function void accept_request(logic nd, logic [FIELD_W-1:0] key,
                                     logic [FIELD_W-1:0] pay);
            logic [FIELD_W-1:0] k;
            int unsigned        slot;
            int unsigned        tag;
            int unsigned        hit;
            int unsigned        tries;
            bit                 stop;
            bit                 found_empty;
            bit                 found_key;
            t_lookup_res        r;
            k = key & key_mask();
            if (nd) begin
                clear_dict();
                n_clear++;
            end
            slot        = slot_of(k);
            tries       = 0;
            stop        = 0;
            found_empty = 0;
            found_key   = 0;
            hit         = 0;
            while (!stop && tries < SLOT_COUNT) begin
                tag = slot_tags[slot % SLOT_COUNT];
                if (tag == 0) begin
                    found_empty = 1;
                    stop        = 1;
                end else if (tag <= CAPACITY && entry_keys[tag-1] == k) begin
                    found_key = 1;
                    hit       = tag - 1;
                    stop      = 1;
                end else begin
                    slot = (slot + 1) & (SLOT_COUNT - 1);
                end
                tries++;
            end
            if (tries > longest_probe) longest_probe = tries;
            r = '0;
            if (found_key) begin
                r.duplicate     = 1'b1;
                r.ordinal       = ORD_OUT_W'(hit);
                r.prior_payload = entry_pays[hit];
                n_dup++;
            end else if (!found_empty || n_entries >= CAPACITY) begin
                r.full_res = 1'b1;
                n_full++;
            end else begin
                entry_keys[n_entries]         = k;
                entry_pays[n_entries]         = pay;
                slot_tags[slot % SLOT_COUNT]  = TAG_W'(n_entries + 1);
                r.ordinal                     = ORD_OUT_W'(n_entries);
                n_entries++;
                n_insert++;
            end
            awaited_results.push_back(r);
        endfunction

        function void check_result(logic dup, logic full, logic [ORD_OUT_W-1:0] ord,
                                   logic [FIELD_W-1:0] prior);
            t_lookup_res want;
            bit          bad;
            if (awaited_results.size() == 0) begin
                if (n_errors < MAX_REPORTS)
                    $display("%0t: unexpected result dup=%0b full=%0b ord=%0d prior=%h",
                             $time, dup, full, ord, prior);
                n_errors++;
                return;
            end
            want = awaited_results.pop_front();
            n_checked++;
            bad = 0;
            if (dup !== want.duplicate) begin
                bad = 1;
                if (n_errors < MAX_REPORTS)
                    $display("%0t: duplicate expected %0b actual %0b",
                             $time, want.duplicate, dup);
            end
            if (full !== want.full_res) begin
                bad = 1;
                if (n_errors < MAX_REPORTS)
                    $display("%0t: full_res expected %0b actual %0b",
                             $time, want.full_res, full);
            end
            if (ord !== want.ordinal) begin
                bad = 1;
                if (n_errors < MAX_REPORTS)
                    $display("%0t: ordinal expected %0d actual %0d",
                             $time, want.ordinal, ord);
            end
            if (prior !== want.prior_payload) begin
                bad = 1;
                if (n_errors < MAX_REPORTS)
                    $display("%0t: prior_payload expected %h actual %h",
                             $time, want.prior_payload, prior);
            end
            if (bad) n_errors++;
        endfunction

        function int unsigned outstanding();
            return awaited_results.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    hdkd_req_if req_if ();
    hdkd_res_if res_if ();

    hashed_duplicate_key_detector_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_dict_scoreboard   sb = new();
    logic [FIELD_W-1:0] dict_keys [$];
    logic [FIELD_W-1:0] old_keys [$];
    int unsigned        n_sent      = 0;
    int unsigned        cycle_count = 0;
    int unsigned        n_long_holds = 0;
    bit                 tx_no_idle  = 0;
    bit                 rx_always   = 0;
    bit                 rx_long_hold = 0;

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, sb.outstanding());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready)
            sb.check_result(res_if.duplicate, res_if.full_res, res_if.ordinal,
                            res_if.prior_payload);
    end

    // result side back-pressure, long hold-offs counted here
    initial begin
        int unsigned rx_hold;
        int          r;
        rx_hold = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_long_hold) begin
                rx_long_hold = 0;
                rx_hold      = LONG_HOLD;
                n_long_holds++;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                res_if.ready <= 1'b0;
            end else if (rx_always) begin
                res_if.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    rx_hold = $urandom_range(15, 60);
                    res_if.ready <= 1'b0;
                end else begin
                    res_if.ready <= (r >= 30);
                end
            end
        end
    end

    task automatic send_request(input logic nd, input logic [FIELD_W-1:0] key,
                                input logic [FIELD_W-1:0] pay);
        req_if.valid    <= 1'b1;
        req_if.new_dict <= nd;
        req_if.key      <= key;
        req_if.payload  <= pay;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.accept_request(nd, key, pay);
        n_sent++;
    endtask

    task automatic idle_tx(input int n);
        if (n > 0) begin
            req_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_tx();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic issue(input logic nd, input logic [FIELD_W-1:0] key,
                         input logic [FIELD_W-1:0] pay, input int gap);
        int unsigned first;
        if (nd) begin
            first = (dict_keys.size() > 16) ? dict_keys.size() - 16 : 0;
            for (int unsigned i = first; i < dict_keys.size(); i++)
                old_keys.push_back(dict_keys[i]);
            while (old_keys.size() > OLD_KEEP) void'(old_keys.pop_front());
            dict_keys.delete();
        end
        dict_keys.push_back(key);
        send_request(nd, key, pay);
        idle_tx(gap);
    endtask

    function automatic int pick_gap();
        int r;
        if (tx_no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [FIELD_W-1:0] pick_payload();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 16) return '1;
        return $urandom;
    endfunction

    function automatic logic [FIELD_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55 || dict_keys.size() == 0) return $urandom;
        if (r < 85) return dict_keys[$urandom_range(0, dict_keys.size() - 1)];
        if (r < 93 && old_keys.size() > 0) return old_keys[$urandom_range(0, old_keys.size() - 1)];
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return FIELD_W'(1) << $urandom_range(0, FIELD_W - 1);
            default: return ~(FIELD_W'(1) << $urandom_range(0, FIELD_W - 1));
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] key_for_slot(input int unsigned s,
                                                          input logic [FIELD_W-1:0] start);
        logic [FIELD_W-1:0] k;
        k = start;
        while (sb.slot_of(k) != s) k++;
        return k;
    endfunction

    // fill to capacity, then absent keys report full and present keys still match
    task automatic fill_dict();
        issue(1'b1, $urandom, pick_payload(), pick_gap());
        while (sb.n_entries < CAPACITY) issue(1'b0, $urandom, pick_payload(), pick_gap());
        repeat (8) begin
            if ($urandom_range(0, 1))
                issue(1'b0, $urandom, pick_payload(), pick_gap());
            else
                issue(1'b0, dict_keys[$urandom_range(0, dict_keys.size() - 1)],
                      pick_payload(), pick_gap());
        end
    endtask

    task automatic run_directed();
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] c1, c2, c3, c4;
        int unsigned        s;
        issue(1'b1, 32'h0000_0000, 32'h0000_0000, 0);
        issue(1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 0);
        issue(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        issue(1'b0, 32'hFFFF_FFFF, 32'h1234_5678, 1);
        issue(1'b0, 32'h8000_0000, 32'h5A5A_5A5A, 0);
        issue(1'b0, 32'h0000_0001, 32'hA5A5_A5A5, 0);
        issue(1'b0, 32'h0000_0000, 32'h0000_0001, 2);
        // clearing forgets earlier keys
        issue(1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 0);
        issue(1'b1, 32'hFFFF_FFFF, 32'h0000_0002, 0);
        // keys sharing one home slot form a probe chain
        base = 32'h0000_1000;
        s    = sb.slot_of(base);
        c1   = key_for_slot(s, base + 1);
        c2   = key_for_slot(s, c1 + 1);
        c3   = key_for_slot(s, c2 + 1);
        c4   = key_for_slot(s, c3 + 1);
        issue(1'b0, base, 32'h0000_0010, 0);
        issue(1'b0, c1, 32'h0000_0011, 0);
        issue(1'b0, c2, 32'h0000_0012, 0);
        issue(1'b0, c3, 32'h0000_0013, 0);
        issue(1'b0, c3, 32'h0000_0014, 0);
        issue(1'b0, c1, 32'h0000_0015, 0);
        issue(1'b0, c4, 32'h0000_0016, 0);
        // chain at the last slot wraps round to slot zero
        s  = SLOT_COUNT - 1;
        c1 = key_for_slot(s, 32'h0002_0000);
        c2 = key_for_slot(s, c1 + 1);
        c3 = key_for_slot(s, c2 + 1);
        issue(1'b0, c1, 32'hFFFF_0000, 0);
        issue(1'b0, c2, 32'h0000_FFFF, 0);
        issue(1'b0, c3, 32'hDEAD_0001, 0);
        issue(1'b0, c3, 32'h0000_0000, 0);
        issue(1'b0, c2, 32'h0000_0000, 0);
    endtask

    task automatic run_random();
        int  len;
        int  r;
        bit  fill_done;
        bit  hold_done;
        logic nd;
        fill_done = 0;
        hold_done = 0;
        while (n_sent < TOTAL_REQS) begin
            tx_no_idle = ($urandom_range(0, 4) == 0);
            rx_always  = ($urandom_range(0, 4) == 0);
            if (!hold_done && n_sent >= 500) begin
                hold_done    = 1;
                rx_always    = 0;
                tx_no_idle   = 1;
                rx_long_hold = 1;
            end
            if (!fill_done && n_sent >= 1000) begin
                fill_done    = 1;
                rx_always    = 0;
                rx_long_hold = 1;
                fill_dict();
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) len = $urandom_range(1, 40);
                else if (r < 95) len = $urandom_range(41, 120);
                else len = $urandom_range(121, 200);
                for (int i = 0; i < len && n_sent < TOTAL_REQS; i++) begin
                    if (i == 0) nd = ($urandom_range(0, 9) != 0);
                    else nd = ($urandom_range(0, 49) == 0);
                    issue(nd, pick_key(), pick_payload(), pick_gap());
                end
            end
            if ($urandom_range(0, 99) < 15) drain_tx();
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.new_dict <= 1'b0;
        req_if.key      <= '0;
        req_if.payload  <= '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        drain_tx();
        fill_dict();
        drain_tx();
        run_random();

        drain_tx();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.outstanding() != 0)
            $display("%0t: %0d expected results never arrived", $time, sb.outstanding());
        $display("covered %0d requests over %0d dictionaries: %0d inserted, %0d duplicates, %0d full",
                 n_sent, sb.n_clear, sb.n_insert, sb.n_dup, sb.n_full);
        $display("longest probe %0d slots, %0d long result hold-offs, %0d results checked, %0d bad",
                 sb.longest_probe, n_long_holds, sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0 && sb.outstanding() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
